// ===== design/cdsq_pkg.sv =====
// Shared types and constants for the card deck shuffle queue.
package cdsq_pkg;

    localparam int CARD_W    = 6;
    localparam int MODE_W    = 2;
    localparam int RWORD_W   = 31;
    localparam int STAT_W    = 2;
    localparam int DIV_CNT_W = $clog2(RWORD_W);

    localparam logic [MODE_W-1:0] MODE_SHUFFLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRAW    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RETURN  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RWORD_W - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B,
        S_DRAW_RD,
        S_DRAW_TAKE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic start_div;
        logic div_step;
        logic rd_a;
        logic rd_b;
        logic wr_a;
        logic wr_b;
        logic draw_rd;
        logic draw_take;
        logic ret_write;
        logic err_empty;
        logic err_full;
        logic done_empty;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              count_zero;
        logic              count_full;
        logic              div_last;
    } dp_stat_t;

endpackage

// ===== design/card_deck_shuffle_queue.sv =====
// Card deck shuffle queue: top level joining controller and datapath.
// Shuffle step: result registered after decode, the bit-serial remainder loop over all
//   31 bits of the random word and four store accesses (two reads, two writes).
// Draw: decode, a store read, then the take. Other requests: decode only. One request at a time.
// A new request is taken while the previous result still waits in the output register.
// Reset: identity deck order via per-entry written bits, count full, pointers zero.
module card_deck_shuffle_queue #(
    parameter int DECK_SIZE = 52
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cdsq_pkg::MODE_W-1:0]     mode,
    input  logic [cdsq_pkg::RWORD_W-1:0]    random_word,
    input  logic [cdsq_pkg::CARD_W-1:0]     card_code,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cdsq_pkg::CARD_W-1:0]     drawn_card,
    output logic                            card_valid,
    output logic [cdsq_pkg::STAT_W-1:0]     status,
    output logic                            shuffle_done
);

    cdsq_pkg::dp_cmd_t  cmd;
    cdsq_pkg::dp_stat_t stat;

    cdsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    cdsq_dp #(
        .DECK_SIZE (DECK_SIZE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode),
        .random_word  (random_word),
        .card_code    (card_code),
        .drawn_card   (drawn_card),
        .card_valid   (card_valid),
        .status       (status),
        .shuffle_done (shuffle_done)
    );

`ifndef ASSERT_OFF
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while a request is in flight");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.ret_write, cmd.wr_a, cmd.wr_b}))
        else $error("more than one store write source");

    a_card_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && card_valid) |-> (status == cdsq_pkg::STAT_OK && !shuffle_done))
        else $error("drawn card with error or shuffle flag");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && out_valid) |-> !out_stall)
        else $error("result overwritten while held");
`endif

endmodule

// ===== design/cdsq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cdsq_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 52
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/cdsq_dp.sv =====
// Datapath: deck store, pointers, serial remainder unit and result registers.
module cdsq_dp #(
    parameter int DECK_SIZE = 52
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdsq_pkg::dp_cmd_t                 cmd,
    output cdsq_pkg::dp_stat_t                stat,
    input  logic [cdsq_pkg::MODE_W-1:0]       mode,
    input  logic [cdsq_pkg::RWORD_W-1:0]      random_word,
    input  logic [cdsq_pkg::CARD_W-1:0]       card_code,
    output logic [cdsq_pkg::CARD_W-1:0]       drawn_card,
    output logic                              card_valid,
    output logic [cdsq_pkg::STAT_W-1:0]       status,
    output logic                              shuffle_done
);

    localparam int PW = $clog2(DECK_SIZE);
    localparam int CW = $clog2(DECK_SIZE + 1);
    localparam logic [PW:0]   DECK_W    = (PW + 1)'(DECK_SIZE);
    localparam logic [CW-1:0] DECK_C    = CW'(DECK_SIZE);
    localparam logic [PW-1:0] LAST_ADDR = PW'(DECK_SIZE - 1);

    function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                           input logic [PW-1:0] offs);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= DECK_W)
        begin
            sum = sum - DECK_W;
        end
        return sum[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] count_next_back(input logic [CW-1:0] cnt);
        logic [CW-1:0] last;
        last = cnt - CW'(1);
        return last[PW-1:0];
    endfunction

    logic [cdsq_pkg::MODE_W-1:0]    mode_reg;
    logic [cdsq_pkg::RWORD_W-1:0]   rshift_reg, rshift_next;
    logic [cdsq_pkg::CARD_W-1:0]    card_reg;
    logic [PW-1:0]                  front_reg, front_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [PW-1:0]                  pos_reg, pos_next;
    logic [CW-1:0]                  div_reg;
    logic [CW-1:0]                  rem_reg, rem_next;
    logic [cdsq_pkg::DIV_CNT_W-1:0] bitcnt_reg;
    logic [DECK_SIZE-1:0]           valid_reg;
    logic                           rd_hit_reg;
    logic [PW-1:0]                  rd_idx_reg;
    logic [cdsq_pkg::CARD_W-1:0]    tmp_a_reg;

    logic [cdsq_pkg::CARD_W-1:0]    res_drawn_reg;
    logic                           res_cvalid_reg;
    logic [cdsq_pkg::STAT_W-1:0]    res_status_reg;
    logic                           res_done_reg;

    logic [cdsq_pkg::CARD_W-1:0]    out_drawn_reg;
    logic                           out_cvalid_reg;
    logic [cdsq_pkg::STAT_W-1:0]    out_status_reg;
    logic                           out_done_reg;

    logic [PW-1:0]                  eff_pos;
    logic [PW-1:0]                  other;
    logic [PW-1:0]                  addr_a;
    logic [PW-1:0]                  addr_b;
    logic [PW-1:0]                  addr_back;
    logic [PW-1:0]                  new_front;
    logic [CW:0]                    trial;
    logic [CW-1:0]                  pos_inc;
    logic                           pos_wrap;

    logic                           ram_wr_en;
    logic [PW-1:0]                  ram_wr_addr;
    logic [cdsq_pkg::CARD_W-1:0]    ram_wr_data;
    logic                           ram_rd_en;
    logic [PW-1:0]                  ram_rd_addr;
    logic [cdsq_pkg::CARD_W-1:0]    ram_q;
    logic [cdsq_pkg::CARD_W-1:0]    rd_data;

    cdsq_ram #(
        .WIDTH (cdsq_pkg::CARD_W),
        .DEPTH (DECK_SIZE)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_q)
    );

    // entries never written read as their own index
    assign rd_data = rd_hit_reg ? ram_q : cdsq_pkg::CARD_W'(rd_idx_reg);

    assign eff_pos   = (CW'(pos_reg) >= count_reg) ? '0 : pos_reg;
    assign other     = pos_reg + rem_reg[PW-1:0];
    assign addr_a    = phys(front_reg, pos_reg);
    assign addr_b    = phys(front_reg, other);
    assign addr_back = phys(front_reg, count_next_back(count_reg));
    assign new_front = (front_reg == '0) ? LAST_ADDR : front_reg - PW'(1);
    assign trial     = {rem_reg, rshift_reg[cdsq_pkg::RWORD_W-1]};
    assign pos_inc   = CW'(pos_reg) + CW'(1);
    assign pos_wrap  = (pos_inc >= count_reg);

    always_comb
    begin
        ram_rd_en   = cmd.rd_a | cmd.rd_b | cmd.draw_rd;
        ram_rd_addr = addr_back;
        if (cmd.rd_a)
        begin
            ram_rd_addr = addr_a;
        end
        else if (cmd.rd_b)
        begin
            ram_rd_addr = addr_b;
        end

        ram_wr_en   = cmd.ret_write | cmd.wr_a | cmd.wr_b;
        ram_wr_addr = new_front;
        ram_wr_data = card_reg;
        if (cmd.wr_a)
        begin
            ram_wr_addr = addr_a;
            ram_wr_data = rd_data;
        end
        else if (cmd.wr_b)
        begin
            ram_wr_addr = addr_b;
            ram_wr_data = tmp_a_reg;
        end
    end

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        rshift_next = rshift_reg;
        if (cmd.ret_write)
        begin
            front_next = new_front;
            count_next = count_reg + CW'(1);
        end
        if (cmd.draw_take)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.start_div)
        begin
            pos_next    = eff_pos;
            rem_next    = '0;
            rshift_next = rshift_reg;
        end
        if (cmd.done_empty)
        begin
            pos_next = '0;
        end
        if (cmd.div_step)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CW'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CW-1:0];
            end
            rshift_next = {rshift_reg[cdsq_pkg::RWORD_W-2:0], 1'b0};
        end
        if (cmd.wr_b)
        begin
            pos_next = pos_wrap ? '0 : pos_inc[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= DECK_C;
            pos_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            if (ram_wr_en)
            begin
                valid_reg[ram_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg       <= mode;
            card_reg       <= card_code;
            res_drawn_reg  <= '0;
            res_cvalid_reg <= 1'b0;
            res_status_reg <= cdsq_pkg::STAT_OK;
            res_done_reg   <= 1'b0;
        end
        if (cmd.accept)
        begin
            rshift_reg <= random_word;
        end
        else
        begin
            rshift_reg <= rshift_next;
        end
        rem_reg <= rem_next;
        if (cmd.start_div)
        begin
            div_reg    <= count_reg - CW'(eff_pos);
            bitcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            bitcnt_reg <= bitcnt_reg + cdsq_pkg::DIV_CNT_W'(1);
        end
        if (ram_rd_en)
        begin
            rd_hit_reg <= valid_reg[ram_rd_addr];
            rd_idx_reg <= ram_rd_addr;
        end
        if (cmd.rd_b)
        begin
            tmp_a_reg <= rd_data;
        end
        if (cmd.draw_take)
        begin
            res_drawn_reg  <= rd_data;
            res_cvalid_reg <= 1'b1;
        end
        if (cmd.err_empty)
        begin
            res_status_reg <= cdsq_pkg::STAT_EMPTY;
        end
        if (cmd.err_full)
        begin
            res_status_reg <= cdsq_pkg::STAT_FULL;
        end
        if (cmd.done_empty || (cmd.wr_b && pos_wrap))
        begin
            res_done_reg <= 1'b1;
        end
        if (cmd.load_out)
        begin
            out_drawn_reg  <= res_drawn_reg;
            out_cvalid_reg <= res_cvalid_reg;
            out_status_reg <= res_status_reg;
            out_done_reg   <= res_done_reg;
        end
    end

    assign stat.mode       = mode_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg >= DECK_C);
    assign stat.div_last   = (bitcnt_reg == cdsq_pkg::DIV_LAST);

    assign drawn_card   = out_drawn_reg;
    assign card_valid   = out_cvalid_reg;
    assign status       = out_status_reg;
    assign shuffle_done = out_done_reg;

endmodule

// ===== design/cdsq_ctrl.sv =====
// Controller: request sequencing and output handshake.
module cdsq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  cdsq_pkg::dp_stat_t stat,
    output cdsq_pkg::dp_cmd_t  cmd
);

    cdsq_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdsq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            cdsq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = cdsq_pkg::S_DECODE;
                end
            end
            cdsq_pkg::S_DECODE:
            begin
                state_next = cdsq_pkg::S_RESULT;
                unique case (stat.mode)
                    cdsq_pkg::MODE_SHUFFLE:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.done_empty = 1'b1;
                        end
                        else
                        begin
                            cmd.start_div = 1'b1;
                            state_next    = cdsq_pkg::S_DIV;
                        end
                    end
                    cdsq_pkg::MODE_DRAW:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.err_empty = 1'b1;
                        end
                        else
                        begin
                            state_next = cdsq_pkg::S_DRAW_RD;
                        end
                    end
                    cdsq_pkg::MODE_RETURN:
                    begin
                        if (stat.count_full)
                        begin
                            cmd.err_full = 1'b1;
                        end
                        else
                        begin
                            cmd.ret_write = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = cdsq_pkg::S_RESULT;
                    end
                endcase
            end
            cdsq_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = cdsq_pkg::S_RD_A;
                end
            end
            cdsq_pkg::S_RD_A:
            begin
                cmd.rd_a   = 1'b1;
                state_next = cdsq_pkg::S_RD_B;
            end
            cdsq_pkg::S_RD_B:
            begin
                cmd.rd_b   = 1'b1;
                state_next = cdsq_pkg::S_WR_A;
            end
            cdsq_pkg::S_WR_A:
            begin
                cmd.wr_a   = 1'b1;
                state_next = cdsq_pkg::S_WR_B;
            end
            cdsq_pkg::S_WR_B:
            begin
                cmd.wr_b   = 1'b1;
                state_next = cdsq_pkg::S_RESULT;
            end
            cdsq_pkg::S_DRAW_RD:
            begin
                cmd.draw_rd = 1'b1;
                state_next  = cdsq_pkg::S_DRAW_TAKE;
            end
            cdsq_pkg::S_DRAW_TAKE:
            begin
                cmd.draw_take = 1'b1;
                state_next    = cdsq_pkg::S_RESULT;
            end
            cdsq_pkg::S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cdsq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdsq_pkg::S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != cdsq_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
